// ===== design/button_debounce_press_classifier_defines.svh =====
// ---------------------------------------------------------------------------
// Assertion macros for the button debounce press classifier
// Shared concurrent assertion forms, clocked on clk and disabled in reset.
// ---------------------------------------------------------------------------
`ifndef BUTTON_DEBOUNCE_PRESS_CLASSIFIER_DEFINES_SVH
`define BUTTON_DEBOUNCE_PRESS_CLASSIFIER_DEFINES_SVH

// Same-cycle implication.
`define BDPC_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define BDPC_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== design/bdpc_pkg.sv =====
// ---------------------------------------------------------------------------
// Button debounce press classifier package
// Event codes, register indexes, reset values and per-button state type.
// ---------------------------------------------------------------------------
package bdpc_pkg;

  // Event reported with each result beat.
  typedef enum logic [1:0] {
    EV_NONE    = 2'd0,
    EV_SHORT   = 2'd1,
    EV_LONG    = 2'd2,
    EV_HOLDING = 2'd3
  } event_t;

  // Configuration register indexes.
  localparam logic [1:0] CFG_DEBOUNCE = 2'd0;
  localparam logic [1:0] CFG_SHORT    = 2'd1;
  localparam logic [1:0] CFG_LONG     = 2'd2;

  // Register reset values.
  localparam logic [15:0] DEBOUNCE_RESET = 16'd100;
  localparam logic [15:0] SHORT_RESET    = 16'd500;
  localparam logic [15:0] LONG_RESET     = 16'd2000;

  // State kept for one button.
  typedef struct packed {
    logic        reading;
    logic        pressed;
    logic [31:0] start;
    logic [31:0] stamp;
  } btn_state_t;

  // Timing limits from the configuration registers.
  typedef struct packed {
    logic [15:0] debounce;
    logic [15:0] short_lim;
    logic [15:0] long_lim;
  } limits_t;

endpackage

// ===== design/bdpc_step.sv =====
// ---------------------------------------------------------------------------
// Button debounce press classifier: single poll update
// Computes one button's next state and the event for one poll.
// ---------------------------------------------------------------------------
module bdpc_step import bdpc_pkg::*; (
  input  btn_state_t  cur,
  input  limits_t     lim,
  input  logic        reading,
  input  logic [31:0] now,
  output btn_state_t  nxt,
  output event_t      ev,
  output logic        changed
);

  logic [31:0] start_eff;
  logic [31:0] stable_dt;
  logic [31:0] held;
  logic [31:0] hold_dt;

  // A change of reading restarts the debounce timer.
  assign start_eff = (reading != cur.reading) ? now : cur.start;
  assign stable_dt = now - start_eff;
  assign held      = now - cur.stamp;

  // Debounced state takes the reading once it has been stable long enough.
  assign changed = (reading != cur.pressed) && (stable_dt >= {16'd0, lim.debounce});

  always_comb begin
    nxt.reading = reading;
    nxt.start   = start_eff;
    nxt.pressed = changed ? reading : cur.pressed;
    nxt.stamp   = changed ? now : cur.stamp;
  end

  // Time since the last change, which is zero when the change is this poll.
  assign hold_dt = changed ? 32'd0 : held;

  // Release classification, then holding while pressed past the long limit.
  always_comb begin
    ev = EV_NONE;
    if (changed && !reading) begin
      priority if (held < {16'd0, lim.short_lim}) begin
        ev = EV_SHORT;
      end else if (held < {16'd0, lim.long_lim}) begin
        ev = EV_LONG;
      end else begin
        ev = EV_NONE;
      end
    end
    if (nxt.pressed && (hold_dt >= {16'd0, lim.long_lim})) begin
      ev = EV_HOLDING;
    end
  end

endmodule

// ===== design/button_debounce_press_classifier.sv =====
// ---------------------------------------------------------------------------
// Button debounce press classifier
// Debounces polled buttons and reports short, long and holding presses.
// ---------------------------------------------------------------------------
// One poll is accepted per cycle while the input is not stalled. The poll is
// captured in an input register; from there the per-button state is read,
// updated and written back while the result register, which drives the
// result beat, is loaded. Per-button state lives in flip-flops, so polls
// of the same button may follow each other in consecutive cycles. The input
// stalls only when both the input register and the result register are full
// and the result beat is stalled. Configuration writes are always ready.

`include "button_debounce_press_classifier_defines.svh"

module button_debounce_press_classifier import bdpc_pkg::*; #(
  parameter int NUM_BUTTONS = 4
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_button_id,
  input  logic        in_pin_level,
  input  logic [31:0] in_now_ms,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  out_button_out,
  output logic [1:0]  out_event_res,
  output logic        out_debounced_pressed,
  output logic        out_any_pressed,
  output logic [31:0] out_last_change_ms,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  localparam int         IDX_W = (NUM_BUTTONS > 1) ? $clog2(NUM_BUTTONS) : 1;
  localparam logic [4:0] NB    = 5'(NUM_BUTTONS);

  // Configuration registers.
  limits_t lim_r;

  // Per-button state and global change time.
  btn_state_t             btn_r [NUM_BUTTONS];
  logic [31:0]            glob_stamp_r;
  logic [NUM_BUTTONS-1:0] pressed_vec;
  logic [NUM_BUTTONS-1:0] pressed_nxt;

  // Input register.
  logic        s1_valid_r;
  logic [1:0]  s1_id_r;
  logic        s1_pin_r;
  logic [31:0] s1_now_r;

  // Result register.
  logic        out_valid_r;
  logic [1:0]  out_id_r;
  event_t      out_ev_r;
  logic        out_dp_r;
  logic        out_any_r;
  logic [31:0] out_stamp_r;

  logic             adv;
  logic             in_range;
  logic [31:0]      idx_wide;
  logic [IDX_W-1:0] idx;
  btn_state_t       cur;
  btn_state_t       nxt;
  event_t           step_ev;
  logic             step_changed;
  logic             reading;

  // Handshake: the result register frees when empty or taken.
  assign adv       = !out_valid_r || !out_stall;
  assign in_stall  = s1_valid_r && !adv;
  assign cfg_ready = 1'b1;

  // Configuration writes; an index beyond the list is ignored.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lim_r.debounce  <= DEBOUNCE_RESET;
      lim_r.short_lim <= SHORT_RESET;
      lim_r.long_lim  <= LONG_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_DEBOUNCE: lim_r.debounce  <= cfg_data;
        CFG_SHORT:    lim_r.short_lim <= cfg_data;
        CFG_LONG:     lim_r.long_lim  <= cfg_data;
        default:      ;
      endcase
    end
  end

  // Input register capture.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (!in_stall) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      s1_id_r  <= in_button_id;
      s1_pin_r <= in_pin_level;
      s1_now_r <= in_now_ms;
    end
  end

  // Select the polled button's state.
  assign in_range = {3'd0, s1_id_r} < NB;
  assign idx_wide = 32'(s1_id_r);
  assign idx      = idx_wide[IDX_W-1:0];
  assign cur      = btn_r[idx];
  assign reading  = ~s1_pin_r;

  bdpc_step u_step (
    .cur     (cur),
    .lim     (lim_r),
    .reading (reading),
    .now     (s1_now_r),
    .nxt     (nxt),
    .ev      (step_ev),
    .changed (step_changed)
  );

  // Pressed flags before and after this poll.
  always_comb begin
    for (int k = 0; k < NUM_BUTTONS; k++) begin
      pressed_vec[k] = btn_r[k].pressed;
    end
    pressed_nxt = pressed_vec;
    if (in_range) begin
      pressed_nxt[idx] = nxt.pressed;
    end
  end

  // State write-back and result register load.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < NUM_BUTTONS; k++) begin
        btn_r[k] <= '0;
      end
      glob_stamp_r <= '0;
      out_valid_r  <= 1'b0;
    end else if (adv) begin
      out_valid_r <= s1_valid_r;
      if (s1_valid_r && in_range) begin
        btn_r[idx] <= nxt;
        if (step_changed) begin
          glob_stamp_r <= s1_now_r;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv && s1_valid_r) begin
      out_id_r    <= s1_id_r;
      out_ev_r    <= in_range ? step_ev : EV_NONE;
      out_dp_r    <= in_range && nxt.pressed;
      out_any_r   <= |pressed_nxt;
      out_stamp_r <= (in_range && step_changed) ? s1_now_r : glob_stamp_r;
    end
  end

  assign out_valid             = out_valid_r;
  assign out_button_out        = out_id_r;
  assign out_event_res         = out_ev_r;
  assign out_debounced_pressed = out_dp_r;
  assign out_any_pressed       = out_any_r;
  assign out_last_change_ms    = out_stamp_r;

  // Holding is only reported for a pressed button.
  `BDPC_ASSERT_IMP(a_hold_pressed, out_valid_r && (out_ev_r == EV_HOLDING), out_dp_r, "holding without press")
  // A release event leaves the button released.
  `BDPC_ASSERT_IMP(a_release_clear, out_valid_r && ((out_ev_r == EV_SHORT) || (out_ev_r == EV_LONG)), !out_dp_r, "release event while pressed")
  // A pressed button is counted in the any-pressed flag.
  `BDPC_ASSERT_IMP(a_any_pressed, out_valid_r && out_dp_r, out_any_r, "any_pressed misses button")
  // A poll in the input register moves to an empty result register.
  `BDPC_ASSERT_NXT(a_advance, s1_valid_r && !out_valid_r, out_valid_r, "poll lost between stages")

endmodule
